// ===== hw/rtl/ifat_pkg.sv =====
// shared types and constants for the in-flight frame ack tracker
// no dependencies; imported by ifat_ring_mem and inflight_frame_ack_tracker_unit
package ifat_pkg;

    localparam int QUEUE_SLOTS_DEF       = 32;
    localparam int PER_DISPLAY_LIMIT_DEF = 4;
    localparam int DISPLAYS_DEF          = 16;

    // first frame id that is never handed out; a push at this id is refused
    localparam logic [30:0] ID_LIMIT = 31'h7FFF_FFFF;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_ACK  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_PUSH_OK      = 2'd0,
        KIND_PUSH_REFUSED = 2'd1,
        KIND_POP          = 2'd2,
        KIND_ACK_EMPTY    = 2'd3
    } t_kind;

    typedef struct packed {
        t_op                op;
        logic [3:0]         display;
        logic [31:0]        source_pos;
        logic signed [31:0] ack_id;
    } t_in_word;

    typedef struct packed {
        t_kind       kind;
        logic [30:0] frame_number;
        logic [3:0]  display_out;
        logic [31:0] pos_out;
        logic        terminate_request;
        logic [5:0]  in_flight_total;
        logic        last;
    } t_out_word;

    // one queued frame
    typedef struct packed {
        logic [30:0] seq_num;
        logic [3:0]  display;
        logic [31:0] pos;
    } t_entry;

endpackage

// ===== hw/rtl/inflight_frame_ack_tracker_unit.sv =====
// in-flight frame ack tracker: shared ring of sent, unacknowledged frames
// depends on ifat_pkg and ifat_ring_mem
// push: the word is registered on accept, and the result word is loaded once the result slot is free
// ack: the word is registered on accept, then one popped word per cycle from the single
//   ring read port while the result slot is free, or one empty-ack word
// reset: synchronous active-low, clears queue pointers and per-display counts and sets
//   the id counter to 1 at once; ring contents are left as they are, no clearing pass
module inflight_frame_ack_tracker_unit #(
    parameter int QUEUE_SLOTS       = ifat_pkg::QUEUE_SLOTS_DEF,
    parameter int PER_DISPLAY_LIMIT = ifat_pkg::PER_DISPLAY_LIMIT_DEF,
    parameter int DISPLAYS          = ifat_pkg::DISPLAYS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ifat_pkg::t_in_word  i_in_word,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ifat_pkg::t_out_word o_out_word
);
    import ifat_pkg::*;

    localparam int AW = $clog2(QUEUE_SLOTS);          // ring index
    localparam int SW = AW + 1;                       // head + count before wrap
    localparam int CW = $clog2(QUEUE_SLOTS + 1);      // fill count
    localparam int DW = $clog2(PER_DISPLAY_LIMIT + 1); // per-display count
    localparam int IW = (DISPLAYS > 1) ? $clog2(DISPLAYS) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PUSH = 3'b010,
        S_ACK  = 3'b100
    } t_state;

    // control state
    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [30:0]     r_next_id, n_next_id;
    logic [DW-1:0]   r_dcount [DISPLAYS];
    logic            r_out_valid, n_out_valid;

    // payload
    t_in_word        r_in;
    t_out_word       r_out_word, n_out_word;

    // per-display count update, one index per cycle
    logic [IW-1:0]   dc_idx;
    logic [DW-1:0]   dc_cur;
    logic            dc_we;
    logic [DW-1:0]   dc_val;

    // ring access
    logic            mem_we;
    logic [AW-1:0]   tail;
    logic [SW-1:0]   tail_sum;
    t_entry          wr_entry;
    t_entry          rd_entry;

    // decisions
    logic            out_free;
    logic            disp_bad;
    logic            q_full;
    logic            d_full;
    logic            id_out;
    logic            push_ok;
    logic            ack_all;
    logic            id_lt;
    logic            id_eq;
    logic            do_pop;
    logic            pop_last;

    ifat_ring_mem #(
        .SLOTS(QUEUE_SLOTS)
    ) u_ring (
        .i_clk      (i_clk),
        .i_wr_en    (mem_we),
        .i_wr_addr  (tail),
        .i_wr_entry (wr_entry),
        .i_rd_addr  (n_head),
        .o_rd_entry (rd_entry)
    );

    // result slot can take a word when empty or being drained this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // tail slot, wrap by one compare-subtract since head + count < 2 * slots
    assign tail_sum = SW'(r_head) + SW'(r_count);
    assign tail     = (tail_sum >= SW'(QUEUE_SLOTS)) ? AW'(tail_sum - SW'(QUEUE_SLOTS))
                                                     : AW'(tail_sum);

    assign wr_entry = '{seq_num: r_next_id, display: r_in.display, pos: r_in.source_pos};

    // the count table is read at the pushed display or at the popped one
    assign dc_idx = (r_state == S_PUSH) ? r_in.display[IW-1:0] : rd_entry.display[IW-1:0];
    assign dc_cur = r_dcount[dc_idx];

    // push checks, in refusal priority order
    assign disp_bad = ({1'b0, r_in.display} >= 5'(DISPLAYS));
    assign q_full   = (r_count >= CW'(QUEUE_SLOTS));
    assign d_full   = (dc_cur >= DW'(PER_DISPLAY_LIMIT));
    assign id_out   = (r_next_id >= ID_LIMIT);
    assign push_ok  = !disp_bad && !q_full && !d_full && !id_out;

    // ack compare against the head entry; queued ids are consecutive, so the
    // head is the final pop once its id reaches the ack id
    assign ack_all  = r_in.ack_id[31];
    assign id_lt    = (rd_entry.seq_num < r_in.ack_id[30:0]);
    assign id_eq    = (rd_entry.seq_num == r_in.ack_id[30:0]);
    assign do_pop   = (r_count != '0) && (ack_all || id_lt || id_eq);
    assign pop_last = (r_count == CW'(1)) || (!ack_all && !id_lt);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_next_id   = r_next_id;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        mem_we      = 1'b0;
        dc_we       = 1'b0;
        dc_val      = dc_cur;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_word.op == OP_ACK) ? S_ACK : S_PUSH;
                end
            end

            S_PUSH: begin
                if (out_free) begin
                    n_out_valid                  = 1'b1;
                    n_out_word.display_out       = r_in.display;
                    n_out_word.pos_out           = r_in.source_pos;
                    n_out_word.last              = 1'b1;
                    if (push_ok) begin
                        mem_we                       = 1'b1;
                        dc_we                        = 1'b1;
                        dc_val                       = DW'(dc_cur + 1'b1);
                        n_count                      = CW'(r_count + 1'b1);
                        n_next_id                    = 31'(r_next_id + 1'b1);
                        n_out_word.kind              = KIND_PUSH_OK;
                        n_out_word.frame_number      = r_next_id;
                        n_out_word.terminate_request = 1'b0;
                        n_out_word.in_flight_total   = 6'(n_count);
                    end else begin
                        n_out_word.kind              = KIND_PUSH_REFUSED;
                        n_out_word.frame_number      = '0;
                        // id space exhausted only counts after the other checks pass
                        n_out_word.terminate_request = !disp_bad && !q_full && !d_full
                                                       && id_out && (r_count == '0);
                        n_out_word.in_flight_total   = 6'(r_count);
                    end
                    n_state = S_IDLE;
                end
            end

            S_ACK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (do_pop) begin
                        dc_we   = (dc_cur != '0);
                        dc_val  = DW'(dc_cur - 1'b1);
                        n_head  = (r_head == AW'(QUEUE_SLOTS - 1)) ? '0
                                                                   : AW'(r_head + 1'b1);
                        n_count = CW'(r_count - 1'b1);
                        n_out_word.kind              = KIND_POP;
                        n_out_word.frame_number      = rd_entry.seq_num;
                        n_out_word.display_out       = rd_entry.display;
                        n_out_word.pos_out           = rd_entry.pos;
                        n_out_word.terminate_request = 1'b0;
                        n_out_word.in_flight_total   = 6'(n_count);
                        n_out_word.last              = pop_last;
                        if (pop_last) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        // only reached on the first look at the head
                        n_out_word.kind              = KIND_ACK_EMPTY;
                        n_out_word.frame_number      = '0;
                        n_out_word.display_out       = '0;
                        n_out_word.pos_out           = '0;
                        n_out_word.terminate_request = 1'b0;
                        n_out_word.in_flight_total   = 6'(r_count);
                        n_out_word.last              = 1'b1;
                        n_state                      = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_next_id   <= 31'd1;
            r_out_valid <= 1'b0;
            for (int i = 0; i < DISPLAYS; i++) begin
                r_dcount[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_next_id   <= n_next_id;
            r_out_valid <= n_out_valid;
            if (dc_we) begin
                r_dcount[dc_idx] <= dc_val;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_in <= i_in_word;
        end
        r_out_word <= n_out_word;
    end

    // busy from accept until the last result word is loaded
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // fill count never passes the ring size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_SLOTS))
        else $error("queue fill count above ring size");

    // an accepted push takes exactly one id
    a_push_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH && out_free && push_ok)
        |=> (r_next_id == 31'($past(r_next_id) + 1'b1)))
        else $error("frame id not advanced by one on push");

    // each pop removes exactly one entry and advances the head
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACK && out_free && do_pop)
        |=> (r_count == CW'($past(r_count) - 1'b1)) && (r_head != $past(r_head)))
        else $error("pop did not remove one entry");

endmodule

// ===== hw/rtl/ifat_ring_mem.sv =====
// ring storage for queued frames: one write port, one registered read port
// depends on ifat_pkg (t_entry)
module ifat_ring_mem #(
    parameter int SLOTS = ifat_pkg::QUEUE_SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(SLOTS)-1:0] i_wr_addr,
    input  ifat_pkg::t_entry         i_wr_entry,
    input  logic [$clog2(SLOTS)-1:0] i_rd_addr,
    output ifat_pkg::t_entry         o_rd_entry
);
    import ifat_pkg::*;

    t_entry r_mem [SLOTS];
    t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_entry <= r_mem[i_rd_addr];
    end

    assign o_rd_entry = r_rd_entry;

endmodule

// ===== tb/tb_inflight_frame_ack_tracker_unit.sv =====
// self-checking testbench for inflight_frame_ack_tracker_unit
// depends on ifat_pkg and the tracker rtl; predicts every result word from its
// own copy of the in-flight queue and compares them in order
module tb_inflight_frame_ack_tracker_unit;

    import ifat_pkg::*;

    localparam int SLOTS       = QUEUE_SLOTS_DEF;
    localparam int DISP_LIMIT  = PER_DISPLAY_LIMIT_DEF;
    localparam int NUM_DISPS   = DISPLAYS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 2 * SLOTS + 8;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } t_stall_kind;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_word  i_in_word = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    inflight_frame_ack_tracker_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predicted tracker state
    t_entry      frames_in_flight[$];
    int          per_display_count[NUM_DISPS];
    logic [30:0] next_frame_id = 31'd1;
    t_out_word   pending_results[$];

    // run bookkeeping
    int          mismatch_count = 0;
    int          words_sent = 0;
    int          results_checked = 0;
    int          frames_queued = 0;
    int          full_refusals = 0;
    int          limit_refusals = 0;
    int          frames_popped = 0;
    int          empty_acks = 0;
    int          cycle_count = 0;

    // sender and receiver idling controls
    int          gap_max = 0;
    int          burst_left = 0;
    t_stall_kind stall_mode = STALL_NONE;
    int          stall_phase = 0;

    // expected result words for one accepted input word
    function automatic void predict_frame_results(t_in_word w);
        t_out_word   r;
        t_entry      head;
        logic [31:0] ack_raw;
        int          popped;
        r = '0;
        if (w.op == OP_PUSH) begin
            r.display_out = w.display;
            r.pos_out     = w.source_pos;
            r.last        = 1'b1;
            // refusal order: full queue, display at limit, id space used up
            if (w.display >= NUM_DISPS || frames_in_flight.size() >= SLOTS
                    || per_display_count[w.display] >= DISP_LIMIT) begin
                r.kind = KIND_PUSH_REFUSED;
                if (frames_in_flight.size() >= SLOTS)
                    full_refusals++;
                else
                    limit_refusals++;
            end else if (next_frame_id >= ID_LIMIT) begin
                r.kind = KIND_PUSH_REFUSED;
                r.terminate_request = (frames_in_flight.size() == 0);
            end else begin
                frames_in_flight.push_back('{seq_num: next_frame_id,
                                             display: w.display,
                                             pos: w.source_pos});
                per_display_count[w.display]++;
                r.kind         = KIND_PUSH_OK;
                r.frame_number = next_frame_id;
                next_frame_id++;
                frames_queued++;
            end
            r.in_flight_total = 6'(frames_in_flight.size());
            pending_results.push_back(r);
        end else begin
            ack_raw = w.ack_id;
            popped  = 0;
            // negative ack id releases everything in flight
            while (frames_in_flight.size() > 0) begin
                head = frames_in_flight[0];
                if (!ack_raw[31] && {1'b0, head.seq_num} > ack_raw)
                    break;
                void'(frames_in_flight.pop_front());
                if (per_display_count[head.display] > 0)
                    per_display_count[head.display]--;
                r                 = '0;
                r.kind            = KIND_POP;
                r.frame_number    = head.seq_num;
                r.display_out     = head.display;
                r.pos_out         = head.pos;
                r.in_flight_total = 6'(frames_in_flight.size());
                pending_results.push_back(r);
                popped++;
                frames_popped++;
            end
            if (popped == 0) begin
                r                 = '0;
                r.kind            = KIND_ACK_EMPTY;
                r.in_flight_total = 6'(frames_in_flight.size());
                r.last            = 1'b1;
                pending_results.push_back(r);
                empty_acks++;
            end else begin
                pending_results[pending_results.size() - 1].last = 1'b1;
            end
        end
    endfunction

    function automatic t_in_word push_word(logic [3:0] disp, logic [31:0] pos);
        t_in_word w;
        w.op         = OP_PUSH;
        w.display    = disp;
        w.source_pos = pos;
        w.ack_id     = $urandom();  // ignored on a push
        return w;
    endfunction

    function automatic t_in_word ack_word(logic [31:0] ack);
        t_in_word w;
        w.op         = OP_ACK;
        w.display    = 4'($urandom_range(0, 15));  // ignored on an ack
        w.source_pos = $urandom();
        w.ack_id     = ack;
        return w;
    endfunction

    // drive one word at the falling edge and hold it until accepted; the
    // sender idles between bursts of random length when gaps are enabled
    task automatic send_word(t_in_word w);
        if (gap_max > 0 && burst_left == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, gap_max - 1)) @(negedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        predict_frame_results(w);
        words_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // receiver stall pattern, changed at the falling edge
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_RANDOM:   i_out_stall <= ($urandom_range(0, 99) < 35);
            STALL_PERIODIC: i_out_stall <= ((stall_phase % 7) >= 4);
            default:        i_out_stall <= 1'b0;
        endcase
    end

    task automatic check_field(string field_name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $error("%s: expected %0h, got %0h", field_name, want, got);
        end
    endtask

    // compare every accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $error("result word with nothing pending: %p", o_out_word);
            end else begin
                check_field("kind", pending_results[0].kind, o_out_word.kind);
                check_field("frame_number", pending_results[0].frame_number,
                            o_out_word.frame_number);
                check_field("display_out", pending_results[0].display_out,
                            o_out_word.display_out);
                check_field("pos_out", pending_results[0].pos_out, o_out_word.pos_out);
                check_field("terminate_request", pending_results[0].terminate_request,
                            o_out_word.terminate_request);
                check_field("in_flight_total", pending_results[0].in_flight_total,
                            o_out_word.in_flight_total);
                check_field("last", pending_results[0].last, o_out_word.last);
                void'(pending_results.pop_front());
                results_checked++;
            end
        end
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("[inflight_frame_ack_tracker_unit] ERROR");
            $finish;
        end
    end

    // empty queue, single frames, ack id extremes, ack below the head
    task automatic test_ack_basics();
        gap_max    = 0;
        stall_mode = STALL_NONE;
        send_word(ack_word(32'd0));
        send_word(ack_word(32'hFFFF_FFFF));
        send_word(push_word(4'd0, 32'h0000_0000));
        send_word(push_word(4'd15, 32'hFFFF_FFFF));
        send_word(push_word(4'd10, 32'hA5A5_5A5A));
        send_word(ack_word(32'd0));                  // head id 1 above ack
        send_word(ack_word(32'd1));                  // pops exactly one
        send_word(ack_word(32'h7FFF_FFFF));          // largest id pops the rest
        send_word(ack_word(32'h8000_0000));          // most negative, empty
        send_word(push_word(4'd5, 32'h5A5A_A5A5));
        send_word(push_word(4'd6, 32'h1234_5678));
        send_word(ack_word(32'd4));                  // partial: stops at id 5
        send_word(ack_word(32'h8000_0000));
    endtask

    // one display pushed past its in-flight limit, then released
    task automatic test_display_limit();
        gap_max    = 4;
        stall_mode = STALL_PERIODIC;
        repeat (DISP_LIMIT + 2)
            send_word(push_word(4'd9, $urandom()));
        send_word(push_word(4'd3, $urandom()));
        send_word(ack_word({1'b0, next_frame_id - 31'd3}));
        send_word(push_word(4'd9, $urandom()));
        send_word(ack_word(32'hFFFF_FFFF));
    endtask

    // fill the whole ring, hit full-queue refusals, flush with a negative ack
    task automatic test_fill_to_capacity(int gaps, t_stall_kind stall);
        int guard;
        gap_max    = gaps;
        stall_mode = stall;
        guard      = 0;
        while (frames_in_flight.size() < SLOTS && guard < 400) begin
            send_word(push_word(4'($urandom_range(0, NUM_DISPS - 1)), $urandom()));
            guard++;
        end
        send_word(push_word(4'($urandom_range(0, NUM_DISPS - 1)), $urandom()));
        send_word(push_word(frames_in_flight[0].display, $urandom()));
        send_word(ack_word($urandom() | 32'h8000_0000));
    endtask

    // mixed pushes and acks; half the ack ids are drawn from the in-flight range or just below it
    task automatic test_random_traffic(int words, int push_pct, int gaps,
                                       t_stall_kind stall);
        logic [31:0] ack;
        int          lo;
        int          hi;
        gap_max    = gaps;
        stall_mode = stall;
        repeat (words) begin
            if ($urandom_range(0, 99) < push_pct) begin
                // narrow display set half the time so limits get hit
                if ($urandom_range(0, 1) == 0)
                    send_word(push_word(4'($urandom_range(0, 3)), $urandom()));
                else
                    send_word(push_word(4'($urandom_range(0, 15)), $urandom()));
            end else begin
                case ($urandom_range(0, 9))
                    0:       ack = 32'hFFFF_FFFF;
                    1:       ack = $urandom() | 32'h8000_0000;
                    2:       ack = $urandom();
                    3:       ack = 32'd0;
                    4:       ack = 32'h7FFF_FFFF;
                    default: begin
                        if (frames_in_flight.size() > 0) begin
                            lo = int'(frames_in_flight[0].seq_num) - 1;
                            hi = int'(frames_in_flight[$].seq_num);
                        end else begin
                            lo = 0;
                            hi = int'(next_frame_id);
                        end
                        ack = $urandom_range(hi, lo);
                    end
                endcase
                send_word(ack_word(ack));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_ack_basics();
        test_display_limit();
        test_fill_to_capacity(0, STALL_NONE);
        test_fill_to_capacity(6, STALL_RANDOM);
        test_random_traffic(120, 55, 0, STALL_NONE);
        test_random_traffic(120, 70, 8, STALL_RANDOM);
        test_random_traffic(100, 40, 5, STALL_PERIODIC);

        // drain, then leave room for any stray word
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (pending_results.size() != 0) begin
            mismatch_count++;
            $error("%0d expected result words never arrived", pending_results.size());
        end
        $display("run covered %0d input words: %0d frames queued, %0d refused on a full ring,",
                 words_sent, frames_queued, full_refusals);
        $display("%0d refused at a display limit, %0d popped, %0d empty acks, %0d words checked",
                 limit_refusals, frames_popped, empty_acks, results_checked);
        if (mismatch_count == 0)
            $display("[inflight_frame_ack_tracker_unit] OK");
        else
            $display("[inflight_frame_ack_tracker_unit] ERROR");
        $finish;
    end

endmodule
